/* rtl/afs_pkg.sv */
`timescale 1ns / 1ps
// Types, constants and the sampling rate table of the ADTS frame scanner.
// No dependencies; the scanner core, input register and header decode import it.
package afs_pkg;

  localparam int unsigned HEADER_BYTES = 7;
  // Bytes of a header kept in the store; the last one is not stored, and the decode does not use it.
  localparam int unsigned HDR_KEEP     = HEADER_BYTES - 1;
  localparam int unsigned IDX_W        = $clog2(HEADER_BYTES);
  localparam int unsigned LEN_W        = 13;
  localparam int unsigned HZ_W         = 17;

  localparam logic [7:0] SYNC_BYTE0 = 8'hff;
  localparam logic [7:0] SYNC_MASK1 = 8'hf0;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_EOS  = 2'd1,
    ST_SYNC = 2'd2,
    ST_LEN  = 2'd3
  } status_t;

  typedef logic [HDR_KEEP-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic            vld;
    logic [7:0]      data;
  } byte_beat_t;

  typedef struct packed {
    logic             sync_ok;
    logic             len_ok;
    logic             mpeg_id;
    logic [1:0]       profile;
    logic [3:0]       rate_index;
    logic [2:0]       channel_config;
    logic [LEN_W-1:0] frame_length;
  } hdr_info_t;

  function automatic logic [HZ_W-1:0] rate_hz_of(input logic [3:0] idx);
    logic [HZ_W-1:0] hz;
    unique case (idx)
      4'd0:    hz = HZ_W'(96000);
      4'd1:    hz = HZ_W'(88200);
      4'd2:    hz = HZ_W'(64000);
      4'd3:    hz = HZ_W'(48000);
      4'd4:    hz = HZ_W'(44100);
      4'd5:    hz = HZ_W'(32000);
      4'd6:    hz = HZ_W'(24000);
      4'd7:    hz = HZ_W'(22050);
      4'd8:    hz = HZ_W'(16000);
      4'd9:    hz = HZ_W'(12000);
      4'd10:   hz = HZ_W'(11025);
      4'd11:   hz = HZ_W'(8000);
      default: hz = '0;
    endcase
    return hz;
  endfunction

endpackage

/* rtl/afs_in_if.sv */
`timescale 1ns / 1ps
// Byte stream channel of the ADTS frame scanner.
// Uses no package.
interface afs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

/* rtl/afs_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the ADTS frame scanner: one beat per parsed header or stop.
// Uses no package.
interface afs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        mpeg_id;
  logic [1:0]  profile;
  logic [3:0]  rate_index;
  logic [16:0] rate_hz;
  logic [2:0]  channel_config;
  logic [12:0] frame_length;
  logic [31:0] frame_count;
  logic [31:0] payload_total;

  modport source (output valid, output status, output mpeg_id, output profile,
                  output rate_index, output rate_hz, output channel_config,
                  output frame_length, output frame_count, output payload_total,
                  input ready);
  modport sink   (input valid, input status, input mpeg_id, input profile,
                  input rate_index, input rate_hz, input channel_config,
                  input frame_length, input frame_count, input payload_total,
                  output ready);
endinterface

/* rtl/afs_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel of the ADTS frame scanner (stream size register).
// Uses no package.
interface afs_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] stream_size;

  modport source (output valid, output stream_size, input ready);
  modport sink   (input valid, input stream_size, output ready);
endinterface

/* rtl/adts_frame_scanner_core.sv */
`timescale 1ns / 1ps
// ADTS frame scanner top level: input register, header tracking, result register.
// Path: a byte accepted into the input register is processed from there; its result beat,
// if any, is loaded into the result register, and a busy result register holds the byte back.
// Throughput: one byte per cycle, limited only by the single result register.
// Reset: rst_n synchronous, active low; clears counters, halt flag and stream size.
// Depends on afs_pkg, afs_in_if, afs_out_if, afs_cfg_if, afs_in_reg, afs_hdr_decode.
module adts_frame_scanner_core
  import afs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  afs_in_if.sink   in_bus,
  afs_out_if.source out_bus,
  afs_cfg_if.sink  cfg_bus
);

  // Configuration: the stream size register is always writable.
  logic [31:0] stream_size_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_size_r <= '0;
    end else if (cfg_bus.valid) begin
      stream_size_r <= cfg_bus.stream_size;
    end
  end

  // Input register stage.
  byte_beat_t beat;
  logic       fire;

  afs_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .advance (fire),
    .beat    (beat)
  );

  // Scanner state.
  hdr_bytes_t       hdr_r;
  logic [IDX_W-1:0] header_index_r, header_index_nxt;
  logic [LEN_W-1:0] skip_left_r, skip_left_nxt;
  logic [31:0]      byte_pos_r, byte_pos_nxt;
  logic [31:0]      header_start_r, header_start_nxt;
  logic [31:0]      frames_r, frames_nxt;
  logic [31:0]      payload_r, payload_nxt;
  logic             halted_r, halted_nxt;

  // Result register.
  logic             out_vld_r, out_vld_nxt;
  status_t          status_r, status_nxt;
  logic             mpeg_id_r, mpeg_id_nxt;
  logic [1:0]       profile_r, profile_nxt;
  logic [3:0]       rate_index_r, rate_index_nxt;
  logic [2:0]       chan_r, chan_nxt;
  logic [LEN_W-1:0] flen_r, flen_nxt;

  hdr_info_t info;

  afs_hdr_decode u_decode (
    .hdr          (hdr_r),
    .stream_size  (stream_size_r),
    .header_start (header_start_r),
    .info         (info)
  );

  // Process the held byte when the result slot is free or being drained.
  assign fire = beat.vld && (!out_vld_r || out_bus.ready);

  logic [32:0]      pos_inc;
  logic [32:0]      eos_sum;
  logic             at_eos;
  logic             last_byte;
  logic             emit;
  logic             hdr_wr;
  logic [32:0]      frames_inc;
  logic [LEN_W-1:0] payload_len;
  logic [32:0]      payload_add;

  assign pos_inc     = {1'b0, byte_pos_r} + 33'd1;
  assign eos_sum     = {1'b0, byte_pos_r} + 33'(HEADER_BYTES);
  assign at_eos      = eos_sum >= {1'b0, stream_size_r};
  assign last_byte   = (header_index_r == IDX_W'(HEADER_BYTES - 1));
  assign frames_inc  = {1'b0, frames_r} + 33'd1;
  assign payload_len = info.frame_length - LEN_W'(HEADER_BYTES);
  assign payload_add = {1'b0, payload_r} + {20'd0, payload_len};
  assign hdr_wr      = fire && !halted_r && (skip_left_r == '0) && !last_byte &&
                       !(header_index_r == '0 && at_eos);

  always_comb begin
    header_index_nxt = header_index_r;
    skip_left_nxt    = skip_left_r;
    byte_pos_nxt     = byte_pos_r;
    header_start_nxt = header_start_r;
    frames_nxt       = frames_r;
    payload_nxt      = payload_r;
    halted_nxt       = halted_r;
    emit             = 1'b0;
    status_nxt       = ST_OK;
    mpeg_id_nxt      = 1'b0;
    profile_nxt      = '0;
    rate_index_nxt   = '0;
    chan_nxt         = '0;
    flen_nxt         = '0;

    if (fire && !halted_r) begin
      // Saturating byte position advance, shared by payload and header bytes.
      byte_pos_nxt = pos_inc[32] ? '1 : pos_inc[31:0];
      priority if (skip_left_r != '0) begin
        skip_left_nxt = skip_left_r - LEN_W'(1);
      end else if (header_index_r == '0 && at_eos) begin
        // No more than a header's length of bytes left: stop here.
        byte_pos_nxt = byte_pos_r;
        halted_nxt   = 1'b1;
        emit         = 1'b1;
        status_nxt   = ST_EOS;
      end else if (!last_byte) begin
        if (header_index_r == '0) begin
          header_start_nxt = byte_pos_r;
        end
        header_index_nxt = header_index_r + IDX_W'(1);
      end else begin
        header_index_nxt = '0;
        emit             = 1'b1;
        priority if (!info.sync_ok) begin
          halted_nxt = 1'b1;
          status_nxt = ST_SYNC;
        end else if (!info.len_ok) begin
          halted_nxt = 1'b1;
          status_nxt = ST_LEN;
        end else begin
          frames_nxt     = frames_inc[32] ? '1 : frames_inc[31:0];
          payload_nxt    = payload_add[32] ? '1 : payload_add[31:0];
          skip_left_nxt  = payload_len;
          status_nxt     = ST_OK;
          mpeg_id_nxt    = info.mpeg_id;
          profile_nxt    = info.profile;
          rate_index_nxt = info.rate_index;
          chan_nxt       = info.channel_config;
          flen_nxt       = info.frame_length;
        end
      end
    end
  end

  // Result slot: load on an emitting byte, drop once the sink takes it.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = emit;
    end else if (out_bus.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_index_r <= '0;
      skip_left_r    <= '0;
      byte_pos_r     <= '0;
      header_start_r <= '0;
      frames_r       <= '0;
      payload_r      <= '0;
      halted_r       <= 1'b0;
      out_vld_r      <= 1'b0;
    end else begin
      header_index_r <= header_index_nxt;
      skip_left_r    <= skip_left_nxt;
      byte_pos_r     <= byte_pos_nxt;
      header_start_r <= header_start_nxt;
      frames_r       <= frames_nxt;
      payload_r      <= payload_nxt;
      halted_r       <= halted_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  // Header bytes: capture all but the last, which the decode never needs stored.
  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_r[header_index_r] <= beat.data;
    end
  end

  // Result payload: hold while the beat waits.
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      status_r     <= status_nxt;
      mpeg_id_r    <= mpeg_id_nxt;
      profile_r    <= profile_nxt;
      rate_index_r <= rate_index_nxt;
      chan_r       <= chan_nxt;
      flen_r       <= flen_nxt;
    end
  end

  assign out_bus.valid          = out_vld_r;
  assign out_bus.status         = status_r;
  assign out_bus.mpeg_id        = mpeg_id_r;
  assign out_bus.profile        = profile_r;
  assign out_bus.rate_index     = rate_index_r;
  // Stop beats carry index zero, so they report the table's first rate.
  assign out_bus.rate_hz        = rate_hz_of(rate_index_r);
  assign out_bus.channel_config = chan_r;
  assign out_bus.frame_length   = flen_r;
  // Totals only change on an emitting byte, so the live counters match the beat.
  assign out_bus.frame_count    = frames_r;
  assign out_bus.payload_total  = payload_r;

  // Once stopped, stay stopped until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  // Payload skipping and header gathering never overlap.
  a_skip_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_left_r != '0) |-> (header_index_r == '0))
    else $error("skipping payload mid-header");

  // Any non-ok result halts the scanner.
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && emit && status_nxt != ST_OK) |=> halted_r)
    else $error("error result without halt");

  // Header index stays inside the header.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_index_r <= IDX_W'(HEADER_BYTES - 1))
    else $error("header index out of range");

endmodule

/* rtl/afs_in_reg.sv */
`timescale 1ns / 1ps
// Input register of the ADTS frame scanner: holds one stream byte until processed.
// Depends on afs_pkg and afs_in_if.
module afs_in_reg
  import afs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  afs_in_if.sink     in_bus,
  input  logic       advance,
  output byte_beat_t beat
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       take;

  assign in_bus.ready = !vld_r || advance;
  assign take         = in_bus.valid && in_bus.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_bus.data_byte;
    end
  end

  assign beat.vld  = vld_r;
  assign beat.data = data_r;

endmodule

/* rtl/afs_hdr_decode.sv */
`timescale 1ns / 1ps
// Header field decode and checks: sync word, frame length and its bounds.
// Depends on afs_pkg.
module afs_hdr_decode
  import afs_pkg::*;
(
  input  hdr_bytes_t  hdr,
  input  logic [31:0] stream_size,
  input  logic [31:0] header_start,
  output hdr_info_t   info
);

  logic [LEN_W-1:0] flen;
  logic [32:0]      room;
  logic             too_long;

  assign flen = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
  // A header that starts past the stream end leaves a negative room: no upper bound.
  assign room     = {1'b0, stream_size} - {1'b0, header_start};
  assign too_long = !room[32] && ({19'd0, flen} > room[31:0]);

  assign info.sync_ok        = (hdr[0] == SYNC_BYTE0) &&
                               ((hdr[1] & SYNC_MASK1) == SYNC_MASK1);
  assign info.len_ok         = (flen >= LEN_W'(HEADER_BYTES)) && !too_long;
  assign info.mpeg_id        = hdr[1][3];
  assign info.profile        = hdr[2][7:6];
  assign info.rate_index     = hdr[2][5:2];
  assign info.channel_config = {hdr[2][0], hdr[3][7:6]};
  assign info.frame_length   = flen;

endmodule
